@@ design/owrs_pkg.sv @@
// Shared types and constants of the 1-wire ROM search engine.
`default_nettype none

package owrs_pkg;

   localparam int RomWidth = 64;
   localparam int PosWidth = 7;
   localparam int IdxWidth = 6;
   localparam int CrcWidth = 8;

   localparam logic [PosWidth-1:0] LastPosition = 7'd64;
   localparam logic [CrcWidth-1:0] CrcPolyReflected = 8'h8C;

   typedef enum logic [1:0] {
      KIND_RESTART  = 2'd0,
      KIND_CONTINUE = 2'd1,
      KIND_BIT_PAIR = 2'd2
   } kind_type;

   typedef enum logic [2:0] {
      ST_SEND_CMD = 3'd0,
      ST_NONE     = 3'd1,
      ST_BIT      = 3'd2,
      ST_OK       = 3'd3,
      ST_ABORT    = 3'd4,
      ST_CRC_BAD  = 3'd5,
      ST_IGNORED  = 3'd6
   } status_type;

endpackage

`default_nettype wire

@@ design/onewire_rom_search_engine.sv @@
// Top level of the 1-wire ROM search decision engine.
// Each accepted beat (pass start or sampled bit pair) is decided in the cycle it is taken and
// its one result beat is shown from the result register on the next cycle, so one item enters
// per cycle: the search state and the CRC8 advance by a single bit step between the request
// and the result register. The request side stalls only while a result beat is held
// by a stall on the result side.
`default_nettype none

module onewire_rom_search_engine
   import owrs_pkg::*;
(
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   output logic                     req_stall,
   input  wire logic [1:0]          req_kind,
   input  wire logic                req_device_absent,
   input  wire logic                req_id_bit,
   input  wire logic                req_complement_bit,
   output logic                     rsp_valid,
   input  wire logic                rsp_stall,
   output logic [2:0]               rsp_status,
   output logic                     rsp_branch_bit,
   output logic [RomWidth-1:0]      rsp_rom_code,
   output logic                     rsp_search_done
);

   logic [RomWidth-1:0] rom_ff, rom_in;
   logic [PosWidth-1:0] last_disc_ff, last_disc_in;
   logic                done_mark_ff, done_mark_in;
   logic [PosWidth-1:0] bit_pos_ff, bit_pos_in;
   logic [PosWidth-1:0] marker_ff, marker_in;
   logic [CrcWidth-1:0] crc_ff, crc_in;
   logic                active_ff, active_in;

   logic                rsp_valid_ff, rsp_valid_in;
   status_type          status_ff, status_in;
   logic                branch_bit_ff, branch_bit_in;
   logic                done_out_ff, done_out_in;

   logic                accept;
   kind_type            kind;
   logic                done_eff;
   logic [IdxWidth-1:0] idx;
   logic                choice;
   logic                feedback;
   logic [CrcWidth-1:0] crc_step;
   logic [PosWidth-1:0] pos_next;

   assign req_stall = rsp_valid_ff && rsp_stall;
   assign accept    = req_valid && !req_stall;
   assign kind      = kind_type'(req_kind);

   assign done_eff = (kind == KIND_RESTART) ? 1'b0 : done_mark_ff;
   assign idx      = IdxWidth'(bit_pos_ff - 7'd1);
   assign pos_next = bit_pos_ff + 7'd1;

   always_comb begin
      priority if (req_id_bit ^ req_complement_bit) begin
         choice = req_id_bit;
      end else if (bit_pos_ff < last_disc_ff) begin
         choice = rom_ff[idx];
      end else begin
         choice = (bit_pos_ff == last_disc_ff);
      end
   end

   assign feedback = crc_ff[0] ^ choice;
   assign crc_step = {1'b0, crc_ff[CrcWidth-1:1]} ^ (feedback ? CrcPolyReflected : '0);

   always_comb begin
      rom_in        = rom_ff;
      last_disc_in  = last_disc_ff;
      done_mark_in  = done_mark_ff;
      bit_pos_in    = bit_pos_ff;
      marker_in     = marker_ff;
      crc_in        = crc_ff;
      active_in     = active_ff;
      status_in     = ST_IGNORED;
      branch_bit_in = 1'b0;
      done_out_in   = 1'b0;
      unique case (kind)
         KIND_RESTART, KIND_CONTINUE: begin
            crc_in       = '0;
            done_mark_in = done_eff;
            if (kind == KIND_RESTART) begin
               last_disc_in = '0;
            end
            if (req_device_absent || done_eff) begin
               last_disc_in = '0;
               active_in    = 1'b0;
               status_in    = ST_NONE;
            end else begin
               bit_pos_in = 7'd1;
               marker_in  = '0;
               active_in  = 1'b1;
               status_in  = ST_SEND_CMD;
            end
         end
         KIND_BIT_PAIR: begin
            if (active_ff) begin
               if (req_id_bit && req_complement_bit) begin
                  last_disc_in = '0;
                  active_in    = 1'b0;
                  status_in    = ST_ABORT;
               end else begin
                  if (!req_id_bit && !req_complement_bit && !choice) begin
                     marker_in = bit_pos_ff;
                  end
                  rom_in[idx]   = choice;
                  crc_in        = crc_step;
                  bit_pos_in    = pos_next;
                  branch_bit_in = choice;
                  if (pos_next > LastPosition) begin
                     active_in = 1'b0;
                     if (crc_step != '0) begin
                        last_disc_in = '0;
                        status_in    = ST_CRC_BAD;
                     end else begin
                        last_disc_in = marker_in;
                        done_mark_in = (marker_in == '0);
                        done_out_in  = (marker_in == '0);
                        status_in    = ST_OK;
                     end
                  end else begin
                     status_in = ST_BIT;
                  end
               end
            end
         end
         default: begin
         end
      endcase
   end

   assign rsp_valid_in = accept || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         rom_ff       <= '0;
         last_disc_ff <= '0;
         done_mark_ff <= 1'b0;
         bit_pos_ff   <= 7'd1;
         marker_ff    <= '0;
         crc_ff       <= '0;
         active_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (accept) begin
            rom_ff       <= rom_in;
            last_disc_ff <= last_disc_in;
            done_mark_ff <= done_mark_in;
            bit_pos_ff   <= bit_pos_in;
            marker_ff    <= marker_in;
            crc_ff       <= crc_in;
            active_ff    <= active_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         status_ff     <= status_in;
         branch_bit_ff <= branch_bit_in;
         done_out_ff   <= done_out_in;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = status_ff;
   assign rsp_branch_bit  = branch_bit_ff;
   assign rsp_rom_code    = rom_ff;
   assign rsp_search_done = done_out_ff;

   a_pos_in_range: assert property (@(posedge clock) disable iff (reset)
      active_ff |-> (bit_pos_ff >= 7'd1 && bit_pos_ff <= LastPosition))
      else $error("bit position out of range during a pass");

   a_done_matches: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && status_ff == ST_OK) |-> (done_out_ff == done_mark_ff))
      else $error("search_done disagrees with done mark");

   a_quiet_fields: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (status_ff == ST_SEND_CMD || status_ff == ST_NONE ||
                        status_ff == ST_ABORT || status_ff == ST_IGNORED))
      |-> (!branch_bit_ff && !done_out_ff))
      else $error("branch bit or done set on a status that carries neither");

   a_bit_keeps_pass: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (status_ff == ST_BIT || status_ff == ST_SEND_CMD)) |-> active_ff)
      else $error("pass not active after a bit or a pass start");

   a_end_of_pass: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (status_ff == ST_OK || status_ff == ST_CRC_BAD))
      |-> (!active_ff && bit_pos_ff == LastPosition + 7'd1))
      else $error("pass end without reaching the last position");

endmodule

`default_nettype wire

@@ dv/onewire_rom_search_engine_tb.sv @@
`timescale 1ns / 1ps
// Testbench for the 1-wire ROM search engine: bus model stimulus, in-line predictor, scoreboard.
module onewire_rom_search_engine_tb;
   import owrs_pkg::*;

   localparam logic [1:0] KindUnknown = 2'd3;
   localparam int HoldCycles = 300;
   localparam int CycleLimit = 200000;
   localparam int BeatsPerPhase = 25;

   typedef struct packed {
      logic [1:0] kind;
      logic       absent;
      logic       id_bit;
      logic       cmp_bit;
   } bus_sample_type;

   typedef struct packed {
      logic [2:0]          status;
      logic                branch_bit;
      logic [RomWidth-1:0] rom;
      logic                done;
   } search_verdict_type;

   typedef struct packed {
      logic [RomWidth-1:0] rom;
      logic [PosWidth-1:0] last_disc;
      logic                done;
      logic [PosWidth-1:0] pos;
      logic [PosWidth-1:0] marker;
      logic [CrcWidth-1:0] crc;
      logic                active;
   } search_state_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic [1:0] req_kind = 2'd0;
   logic req_device_absent = 1'b0;
   logic req_id_bit = 1'b0;
   logic req_complement_bit = 1'b0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic [2:0] rsp_status;
   logic rsp_branch_bit;
   logic [RomWidth-1:0] rsp_rom_code;
   logic rsp_search_done;

   bus_sample_type bus_beats_pending[$];
   search_verdict_type expected_verdicts[$];
   logic [RomWidth-1:0] devices[$];
   search_state_type gen_state;
   search_state_type model_state;
   bus_sample_type beat_on_wire;
   int send_idle_pct = 0;
   int recv_stall_pct = 0;
   int phase_beats = 0;
   int errors = 0;
   int cycle_count = 0;
   logic rsp_hold = 1'b0;
   event rsp_hold_start;

   onewire_rom_search_engine u_top (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_kind           (req_kind),
      .req_device_absent  (req_device_absent),
      .req_id_bit         (req_id_bit),
      .req_complement_bit (req_complement_bit),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_status         (rsp_status),
      .rsp_branch_bit     (rsp_branch_bit),
      .rsp_rom_code       (rsp_rom_code),
      .rsp_search_done    (rsp_search_done)
   );

   always #10 clock = ~clock;

   function automatic search_state_type search_reset();
      search_state_type s;
      s = '0;
      s.pos = 7'd1;
      return s;
   endfunction

   function automatic logic [CrcWidth-1:0] crc8_shift(logic [CrcWidth-1:0] crc, logic b);
      logic [CrcWidth-1:0] nxt;
      nxt = {1'b0, crc[CrcWidth-1:1]};
      if (crc[0] ^ b) nxt = nxt ^ CrcPolyReflected;
      return nxt;
   endfunction

   task automatic search_step(inout search_state_type s, input bus_sample_type b,
                              output search_verdict_type v);
      logic [PosWidth-1:0] m;
      logic [PosWidth-1:0] m_less;
      logic [IdxWidth-1:0] idx;
      logic g;
      v = '0;
      v.status = ST_IGNORED;
      if (b.kind == KIND_RESTART || b.kind == KIND_CONTINUE) begin
         if (b.kind == KIND_RESTART) begin
            s.last_disc = '0;
            s.done = 1'b0;
         end
         s.crc = '0;
         if (b.absent || s.done) begin
            s.last_disc = '0;
            s.active = 1'b0;
            v.status = ST_NONE;
         end else begin
            s.pos = 7'd1;
            s.marker = '0;
            s.active = 1'b1;
            v.status = ST_SEND_CMD;
         end
      end else if (b.kind == KIND_BIT_PAIR && s.active) begin
         if (b.id_bit && b.cmp_bit) begin
            s.last_disc = '0;
            s.active = 1'b0;
            v.status = ST_ABORT;
         end else begin
            m = s.pos;
            m_less = m - 7'd1;
            idx = m_less[IdxWidth-1:0];
            if (b.id_bit || b.cmp_bit) begin
               g = b.id_bit;
            end else begin
               if (m < s.last_disc) g = s.rom[idx];
               else g = (m == s.last_disc);
               if (!g) s.marker = m;
            end
            s.rom[idx] = g;
            s.crc = crc8_shift(s.crc, g);
            s.pos = m + 7'd1;
            v.branch_bit = g;
            if (s.pos > LastPosition) begin
               s.active = 1'b0;
               if (s.crc != '0) begin
                  s.last_disc = '0;
                  v.status = ST_CRC_BAD;
               end else begin
                  s.last_disc = s.marker;
                  s.done = (s.marker == '0);
                  v.status = ST_OK;
                  v.done = s.done;
               end
            end else begin
               v.status = ST_BIT;
            end
         end
      end
      v.rom = s.rom;
   endtask

   task automatic queue_beat(input logic [1:0] kind, input logic absent, input logic id_bit,
                             input logic cmp_bit, output search_verdict_type v);
      bus_sample_type b;
      b = {kind, absent, id_bit, cmp_bit};
      bus_beats_pending.push_back(b);
      search_step(gen_state, b, v);
      phase_beats++;
   endtask

   task automatic add_device(input logic [55:0] body);
      logic [CrcWidth-1:0] crc;
      crc = '0;
      for (int k = 0; k < 56; k++) crc = crc8_shift(crc, body[k]);
      devices.push_back({crc, body});
   endtask

   task automatic make_devices(input int count);
      logic [55:0] base;
      logic [55:0] body;
      int k;
      devices.delete();
      base = 56'({$urandom, $urandom});
      repeat (count) begin
         body = base;
         repeat ($urandom_range(4)) begin
            k = $urandom_range(55);
            body[k] = ~body[k];
         end
         add_device(body);
      end
   endtask

   // wired-AND bus: only devices still on the chosen path answer
   task automatic bus_pass(input logic [1:0] kind, output search_verdict_type v);
      logic [RomWidth-1:0] on_path[$];
      logic id_and;
      logic cmp_and;
      on_path = devices;
      queue_beat(kind, 1'b0, 1'($urandom_range(1)), 1'($urandom_range(1)), v);
      if (v.status == ST_SEND_CMD) begin
         for (int m = 0; m < RomWidth; m++) begin
            id_and = 1'b1;
            cmp_and = 1'b1;
            foreach (on_path[i]) begin
               id_and &= on_path[i][m];
               cmp_and &= ~on_path[i][m];
            end
            queue_beat(KIND_BIT_PAIR, 1'($urandom_range(1)), id_and, cmp_and, v);
            if (v.status != ST_BIT) break;
            for (int i = on_path.size() - 1; i >= 0; i--)
               if (on_path[i][m] != v.branch_bit) on_path.delete(i);
         end
      end
   endtask

   task automatic full_search();
      search_verdict_type v;
      int guard;
      guard = 0;
      bus_pass(KIND_RESTART, v);
      while (v.status == ST_OK && !v.done && guard < 16) begin
         bus_pass(KIND_CONTINUE, v);
         guard++;
      end
      if (v.status == ST_OK) bus_pass(KIND_CONTINUE, v);
   endtask

   task automatic garbled_pass();
      search_verdict_type v;
      int pick;
      logic id_bit;
      logic cmp_bit;
      queue_beat(2'($urandom_range(1)), 1'b0, 1'($urandom_range(1)), 1'($urandom_range(1)), v);
      repeat ($urandom_range(70)) begin
         pick = $urandom_range(79);
         id_bit = 1'($urandom_range(1));
         cmp_bit = ~id_bit;
         if (pick == 0) begin
            id_bit = 1'b1;
            cmp_bit = 1'b1;
         end else if (pick < 12) begin
            id_bit = 1'b0;
            cmp_bit = 1'b0;
         end
         if (pick == 79)
            queue_beat(2'($urandom_range(1)), 1'b0, id_bit, cmp_bit, v);
         else
            queue_beat(KIND_BIT_PAIR, 1'($urandom_range(1)), id_bit, cmp_bit, v);
      end
   endtask

   task automatic noise_burst();
      search_verdict_type v;
      repeat ($urandom_range(1, 6))
         queue_beat(2'($urandom_range(3)), 1'($urandom_range(1)), 1'($urandom_range(1)),
                    1'($urandom_range(1)), v);
   endtask

   task automatic random_scenarios();
      search_verdict_type v;
      int pick;
      while (phase_beats < BeatsPerPhase) begin
         pick = $urandom_range(9);
         if (pick < 5) begin
            make_devices($urandom_range(1, 3));
            full_search();
         end else if (pick < 7) begin
            garbled_pass();
         end else if (pick < 8) begin
            queue_beat(2'($urandom_range(1)), 1'b1, 1'($urandom_range(1)),
                       1'($urandom_range(1)), v);
         end else begin
            noise_burst();
         end
      end
   endtask

   task automatic wait_quiet();
      while (bus_beats_pending.size() != 0 || req_valid || expected_verdicts.size() != 0)
         @(posedge clock);
   endtask

   always @(posedge clock) begin
      search_verdict_type v;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            search_step(model_state, beat_on_wire, v);
            expected_verdicts.push_back(v);
         end
         if (!req_valid || !req_stall) begin
            if (bus_beats_pending.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               beat_on_wire = bus_beats_pending.pop_front();
               req_valid <= 1'b1;
               req_kind <= beat_on_wire.kind;
               req_device_absent <= beat_on_wire.absent;
               req_id_bit <= beat_on_wire.id_bit;
               req_complement_bit <= beat_on_wire.cmp_bit;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin
      search_verdict_type want;
      search_verdict_type got;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            got = {rsp_status, rsp_branch_bit, rsp_rom_code, rsp_search_done};
            if (expected_verdicts.size() == 0) begin
               $display("%0t: unexpected result beat: status %0d bit %0b rom %h done %0b",
                        $time, got.status, got.branch_bit, got.rom, got.done);
               errors++;
            end else begin
               want = expected_verdicts.pop_front();
               if (got !== want) begin
                  $display("%0t: expected status %0d bit %0b rom %h done %0b", $time,
                           want.status, want.branch_bit, want.rom, want.done);
                  $display("%0t: actual   status %0d bit %0b rom %h done %0b", $time,
                           got.status, got.branch_bit, got.rom, got.done);
                  errors++;
               end
            end
         end
         rsp_stall <= rsp_hold || ($urandom_range(99) < recv_stall_pct);
      end
   end

   always begin
      @(rsp_hold_start);
      @(posedge clock);
      rsp_hold <= 1'b1;
      repeat (HoldCycles) @(posedge clock);
      rsp_hold <= 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CycleLimit) begin
         $display("onewire_rom_search_engine_tb NOT OK");
         $finish;
      end
   end

   initial begin
      search_verdict_type v;
      gen_state = search_reset();
      model_state = search_reset();
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      queue_beat(KIND_BIT_PAIR, 1'b0, 1'b1, 1'b0, v);
      queue_beat(KindUnknown, 1'b1, 1'b1, 1'b1, v);
      queue_beat(KIND_RESTART, 1'b1, 1'b0, 1'b0, v);
      queue_beat(KIND_CONTINUE, 1'b1, 1'b1, 1'b1, v);
      queue_beat(KIND_RESTART, 1'b0, 1'b0, 1'b0, v);
      queue_beat(KIND_BIT_PAIR, 1'b0, 1'b1, 1'b0, v);
      queue_beat(KIND_BIT_PAIR, 1'b1, 1'b0, 1'b1, v);
      queue_beat(KIND_BIT_PAIR, 1'b0, 1'b0, 1'b0, v);
      queue_beat(KindUnknown, 1'b0, 1'b0, 1'b0, v);
      queue_beat(KIND_BIT_PAIR, 1'b1, 1'b1, 1'b1, v);
      queue_beat(KIND_BIT_PAIR, 1'b0, 1'b0, 1'b0, v);
      queue_beat(KIND_CONTINUE, 1'b0, 1'b0, 1'b0, v);
      queue_beat(KIND_BIT_PAIR, 1'b1, 1'b1, 1'b0, v);
      queue_beat(KIND_RESTART, 1'b0, 1'b1, 1'b1, v);
      queue_beat(KIND_BIT_PAIR, 1'b1, 1'b0, 1'b0, v);
      queue_beat(KIND_CONTINUE, 1'b0, 1'b0, 1'b1, v);

      devices.delete();
      add_device('1);
      add_device('0);
      full_search();
      random_scenarios();
      -> rsp_hold_start;
      wait_quiet();

      for (int phase = 1; phase < 4; phase++) begin
         @(negedge clock);
         unique case (phase)
            1: begin
               send_idle_pct = 55;
               recv_stall_pct = 0;
            end
            2: begin
               send_idle_pct = 0;
               recv_stall_pct = 55;
            end
            default: begin
               send_idle_pct = 31;
               recv_stall_pct = 31;
            end
         endcase
         phase_beats = 0;
         random_scenarios();
         wait_quiet();
      end

      repeat (8) @(posedge clock);
      if (errors == 0)
         $display("onewire_rom_search_engine_tb OK");
      else
         $display("onewire_rom_search_engine_tb NOT OK");
      $finish;
   end

endmodule

@@ filelist.f @@
design/owrs_pkg.sv
design/onewire_rom_search_engine.sv
dv/onewire_rom_search_engine_tb.sv
